[hw/rtl/mfva_pkg.sv]
// Shared types, constants and helper functions for the MIDI-to-FM voice allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package mfva_pkg;

  localparam int VOL_W = 7;

  // Upper nibble of MIDI status bytes.
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_POLY_AT  = 4'hA;
  localparam logic [3:0] TYPE_CTRL     = 4'hB;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_CHAN_AT  = 4'hD;
  localparam logic [3:0] TYPE_BEND     = 4'hE;

  localparam logic [6:0] CC_VOLUME    = 7'd7;
  localparam logic [6:0] CC_RESET_ALL = 7'd121;
  localparam logic [6:0] CC_NOTES_OFF = 7'd123;

  localparam logic [6:0] VOL_DEFAULT = 7'd100;

  typedef enum logic [2:0] {
    CMD_NOTE_ON,
    CMD_NOTE_OFF,
    CMD_CC_VOL,
    CMD_CC_VOL_RESET,
    CMD_ALL_OFF
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [3:0] ch;
    logic [6:0] d0;
    logic [6:0] d1;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_STEAL_WR,
    S_CALC,
    S_NOTE_WR,
    S_OFF_WR,
    S_VOL_PICK,
    S_VOL_WR,
    S_ALL_WR
  } back_state_t;

  // Exact x/127 for x below 127*128: estimate with x>>7, then one correction.
  function automatic logic [6:0] div127(input logic [13:0] x);
    logic [6:0] q0;
    logic [7:0] r;
    logic [7:0] q;
    q0 = x[13:7];
    r  = {1'b0, x[6:0]} + {1'b0, q0};
    q  = {1'b0, q0} + ((r >= 8'd127) ? 8'd1 : 8'd0);
    return q[6:0];
  endfunction

  // Exact note/12 for a 7-bit note.
  function automatic logic [3:0] div12(input logic [6:0] n);
    logic [12:0] p;
    p = 13'(n) * 13'd43;
    return p[12:9];
  endfunction

  function automatic logic [9:0] semitone_fnum(input logic [3:0] s);
    logic [9:0] f;
    case (s)
      4'd0:    f = 10'h157;
      4'd1:    f = 10'h16B;
      4'd2:    f = 10'h181;
      4'd3:    f = 10'h198;
      4'd4:    f = 10'h1B0;
      4'd5:    f = 10'h1CA;
      4'd6:    f = 10'h1E5;
      4'd7:    f = 10'h202;
      4'd8:    f = 10'h220;
      4'd9:    f = 10'h241;
      4'd10:   f = 10'h263;
      4'd11:   f = 10'h287;
      default: f = 10'h157;
    endcase
    return f;
  endfunction

  function automatic logic [9:0] note_fnum(input logic [6:0] n);
    logic [3:0] q;
    logic [6:0] s;
    q = div12(n);
    s = n - (7'(q) * 7'd12);
    return semitone_fnum(s[3:0]);
  endfunction

  // Block number in bits 4:2 and fnum high bits in 1:0.
  function automatic logic [7:0] pitch_high(input logic [6:0] n);
    logic [3:0] q;
    logic [2:0] blk;
    logic [9:0] f;
    q   = div12(n);
    blk = (q == 4'd0) ? 3'd0 : ((q > 4'd8) ? 3'd7 : 3'(q - 4'd1));
    f   = note_fnum(n);
    return {3'b000, blk, f[9:8]};
  endfunction

  function automatic logic [7:0] op_mod(input logic [3:0] v);
    logic [7:0] o;
    case (v)
      4'd0:    o = 8'h00;
      4'd1:    o = 8'h01;
      4'd2:    o = 8'h02;
      4'd3:    o = 8'h08;
      4'd4:    o = 8'h09;
      4'd5:    o = 8'h0A;
      4'd6:    o = 8'h10;
      4'd7:    o = 8'h11;
      4'd8:    o = 8'h12;
      default: o = 8'h00;
    endcase
    return o;
  endfunction

  function automatic logic [7:0] op_car(input logic [3:0] v);
    return op_mod(v) + 8'h03;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mfva_front.sv]
// MIDI byte parser: running status, data byte counting, command classification.
// Depends on mfva_pkg; feeds commands into mfva_queue.
`default_nettype none
module mfva_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    midi_byte,
  output logic               push,
  output mfva_pkg::cmd_t     push_cmd
);
  import mfva_pkg::*;

  logic [7:0] running_status_r;
  logic [1:0] bytes_expected_r;
  logic [1:0] bytes_received_r;
  logic [6:0] first_data_r;
  logic [1:0] recv_inc;
  logic       complete;
  logic [6:0] d0;
  logic [6:0] d1;

  assign recv_inc = bytes_received_r + 2'd1;
  assign complete = accept && !midi_byte[7] && (bytes_expected_r != 2'd0) &&
                    (recv_inc >= bytes_expected_r);
  assign d0 = (bytes_received_r == 2'd0) ? midi_byte[6:0] : first_data_r;
  assign d1 = (bytes_expected_r == 2'd2) ? midi_byte[6:0] : 7'd0;

  always_comb begin
    push          = 1'b0;
    push_cmd.op   = CMD_NOTE_OFF;
    push_cmd.ch   = running_status_r[3:0];
    push_cmd.d0   = d0;
    push_cmd.d1   = d1;
    if (complete) begin
      unique case (running_status_r[7:4])
        TYPE_NOTE_ON: begin
          push        = 1'b1;
          push_cmd.op = (d1 == 7'd0) ? CMD_NOTE_OFF : CMD_NOTE_ON;
        end
        TYPE_NOTE_OFF: begin
          push        = 1'b1;
          push_cmd.op = CMD_NOTE_OFF;
        end
        TYPE_CTRL: begin
          if (d0 == CC_VOLUME) begin
            push        = 1'b1;
            push_cmd.op = CMD_CC_VOL;
          end else if (d0 == CC_RESET_ALL) begin
            push        = 1'b1;
            push_cmd.op = CMD_CC_VOL_RESET;
          end else if (d0 == CC_NOTES_OFF) begin
            push        = 1'b1;
            push_cmd.op = CMD_ALL_OFF;
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_status_r <= 8'd0;
      bytes_expected_r <= 2'd0;
      bytes_received_r <= 2'd0;
      first_data_r     <= 7'd0;
    end else if (accept) begin
      if (midi_byte[7]) begin
        running_status_r <= midi_byte;
        bytes_received_r <= 2'd0;
        case (midi_byte[7:4])
          TYPE_NOTE_OFF, TYPE_NOTE_ON, TYPE_POLY_AT, TYPE_CTRL, TYPE_BEND:
            bytes_expected_r <= 2'd2;
          TYPE_PROGRAM, TYPE_CHAN_AT:
            bytes_expected_r <= 2'd1;
          default:
            bytes_expected_r <= 2'd0;
        endcase
      end else if (bytes_expected_r != 2'd0) begin
        if (bytes_received_r == 2'd0) begin
          first_data_r <= midi_byte[6:0];
        end
        bytes_received_r <= complete ? 2'd0 : recv_inc;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mfva_queue.sv]
// Two-entry command queue between the parser and the voice engine.
// Depends on mfva_pkg for the command type.
`default_nettype none
module mfva_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire mfva_pkg::cmd_t      push_cmd,
  input  wire logic                pop,
  output mfva_pkg::cmd_t           head,
  output mfva_pkg::q_status_t      status
);
  import mfva_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign head         = entry_r[rd_ptr_r];
  assign status.empty = (count_r == 2'd0);
  assign status.full  = (count_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && status.full && !pop)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && status.empty)) else $error("queue underflow");

endmodule
`default_nettype wire

[hw/rtl/mfva_back.sv]
// Voice engine: allocation, stealing, carrier level arithmetic and register writes.
// Depends on mfva_pkg; takes commands from mfva_queue.
`default_nettype none
module mfva_back #(
  parameter int VOICE_COUNT = 9,
  parameter int AGE_BITS    = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [6:0]           cfg_master_volume,
  input  wire mfva_pkg::cmd_t       head,
  input  wire mfva_pkg::q_status_t  q_status,
  output logic                      pop,
  output logic                      out_valid,
  output logic [7:0]                out_reg_addr,
  output logic [7:0]                out_reg_data,
  output logic                      out_last_write
);
  import mfva_pkg::*;

  localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [VW-1:0] LAST_V = VW'(VOICE_COUNT - 1);

  back_state_t state_r, state_nxt;

  logic [VOICE_COUNT-1:0] voice_busy_r;
  logic [3:0]             voice_owner_r    [VOICE_COUNT];
  logic [6:0]             voice_note_r     [VOICE_COUNT];
  logic [6:0]             voice_velocity_r [VOICE_COUNT];
  logic [AGE_BITS-1:0]    voice_age_r      [VOICE_COUNT];
  logic [AGE_BITS-1:0]    age_count_r;
  logic [6:0]             channel_volume_r [16];
  logic [6:0]             master_volume_r;

  cmd_t                   cmd_r;
  logic [VW-1:0]          v_r;
  logic [VW-1:0]          idx_r;
  logic [VW-1:0]          pick_r;
  logic [AGE_BITS-1:0]    best_r;
  logic [VOICE_COUNT-1:0] mask_r;
  logic [6:0]             vel_r;
  logic [6:0]             e_r;
  logic [1:0]             step_r;
  logic [3:0]             k_r;

  logic [VOICE_COUNT-1:0] match_vec;
  logic [VOICE_COUNT-1:0] chan_vec;
  logic [VW-1:0]          lowest_free;
  logic [VW-1:0]          lowest_match;
  logic [VW-1:0]          lowest_mask;
  logic                   age_lt;
  logic [6:0]             opnd;
  logic [6:0]             fac;
  logic [13:0]            prod;
  logic [6:0]             e_nxt;
  logic [7:0]             level;
  logic [3:0]             v4;
  logic [3:0]             idx4;
  logic [3:0]             slot;
  logic [7:0]             opr;
  logic [9:0]             fnum;

  always_comb begin
    lowest_free  = '0;
    lowest_match = '0;
    lowest_mask  = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      match_vec[i] = voice_busy_r[i] && (voice_owner_r[i] == head.ch) &&
                     (voice_note_r[i] == head.d0);
      chan_vec[i]  = voice_busy_r[i] && (voice_owner_r[i] == head.ch);
      if (!voice_busy_r[i]) lowest_free  = VW'(i);
      if (match_vec[i])     lowest_match = VW'(i);
      if (mask_r[i])        lowest_mask  = VW'(i);
    end
  end

  assign age_lt = voice_age_r[idx_r] < best_r;

  // One multiply and one divide by 127 per CALC cycle.
  assign opnd  = (step_r == 2'd0) ? channel_volume_r[cmd_r.ch] : e_r;
  assign fac   = (step_r == 2'd0) ? master_volume_r :
                 ((step_r == 2'd1) ? vel_r : 7'd63);
  assign prod  = 14'(opnd) * 14'(fac);
  assign e_nxt = div127(prod);
  assign level = 8'd63 - {1'b0, e_r};

  assign v4   = 4'(v_r);
  assign idx4 = 4'(idx_r);
  assign slot = (k_r < 4'd5) ? k_r : (k_r - 4'd5);
  assign opr  = (k_r < 4'd5) ? op_mod(v4) : op_car(v4);
  assign fnum = note_fnum(cmd_r.d0);

  assign pop = (state_r == S_IDLE) && !q_status.empty;

  always_comb begin
    state_nxt      = state_r;
    out_valid      = 1'b0;
    out_reg_addr   = 8'd0;
    out_reg_data   = 8'd0;
    out_last_write = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          unique case (head.op)
            CMD_NOTE_ON:      state_nxt = (&voice_busy_r) ? S_SCAN : S_CALC;
            CMD_NOTE_OFF:     state_nxt = (|match_vec) ? S_OFF_WR : S_IDLE;
            CMD_CC_VOL:       state_nxt = S_VOL_PICK;
            CMD_ALL_OFF:      state_nxt = S_ALL_WR;
            default:          state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (idx_r == LAST_V) state_nxt = S_STEAL_WR;
      end
      S_STEAL_WR: begin
        out_valid    = 1'b1;
        out_reg_addr = 8'hB0 + 8'(v4);
        state_nxt    = S_CALC;
      end
      S_CALC: begin
        if (step_r == 2'd2) begin
          state_nxt = (cmd_r.op == CMD_NOTE_ON) ? S_NOTE_WR : S_VOL_WR;
        end
      end
      S_NOTE_WR: begin
        out_valid = 1'b1;
        if (k_r < 4'd10) begin
          case (slot)
            4'd0: begin out_reg_addr = 8'h20 + opr; out_reg_data = 8'h01; end
            4'd1: begin out_reg_addr = 8'h60 + opr; out_reg_data = 8'hF0; end
            4'd2: begin out_reg_addr = 8'h80 + opr; out_reg_data = 8'h77; end
            4'd3: begin out_reg_addr = 8'hE0 + opr; out_reg_data = 8'h00; end
            default: begin
              out_reg_addr = 8'h40 + opr;
              out_reg_data = (k_r < 4'd5) ? 8'h20 : level;
            end
          endcase
        end else if (k_r == 4'd10) begin
          out_reg_addr = 8'hC0 + 8'(v4);
        end else if (k_r == 4'd11) begin
          out_reg_addr = 8'hA0 + 8'(v4);
          out_reg_data = fnum[7:0];
        end else begin
          out_reg_addr   = 8'hB0 + 8'(v4);
          out_reg_data   = pitch_high(cmd_r.d0) | 8'h20;
          out_last_write = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_OFF_WR: begin
        out_valid      = 1'b1;
        out_reg_addr   = 8'hB0 + 8'(v4);
        out_reg_data   = pitch_high(cmd_r.d0);
        out_last_write = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_VOL_PICK: begin
        state_nxt = (mask_r == '0) ? S_IDLE : S_CALC;
      end
      S_VOL_WR: begin
        out_valid      = 1'b1;
        out_reg_addr   = 8'h40 + op_car(v4);
        out_reg_data   = level;
        out_last_write = (mask_r == '0);
        state_nxt      = (mask_r == '0) ? S_IDLE : S_VOL_PICK;
      end
      S_ALL_WR: begin
        out_valid      = 1'b1;
        out_reg_addr   = 8'hB0 + 8'(idx4);
        out_last_write = (idx_r == LAST_V);
        if (idx_r == LAST_V) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_busy_r    <= '0;
      age_count_r     <= '0;
      master_volume_r <= VOL_DEFAULT;
      mask_r          <= '0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        voice_owner_r[i]    <= 4'd0;
        voice_note_r[i]     <= 7'd0;
        voice_velocity_r[i] <= VOL_DEFAULT;
        voice_age_r[i]      <= '0;
      end
      for (int c = 0; c < 16; c++) begin
        channel_volume_r[c] <= VOL_DEFAULT;
      end
    end else begin
      if (cfg_we) master_volume_r <= cfg_master_volume;
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            cmd_r <= head;
            case (head.op)
              CMD_NOTE_ON: begin
                vel_r  <= head.d1;
                step_r <= 2'd0;
                v_r    <= lowest_free;
                idx_r  <= '0;
                pick_r <= '0;
                best_r <= '1;
              end
              CMD_NOTE_OFF: v_r <= lowest_match;
              CMD_CC_VOL: begin
                channel_volume_r[head.ch] <= head.d1;
                mask_r <= chan_vec;
              end
              CMD_CC_VOL_RESET: channel_volume_r[head.ch] <= VOL_DEFAULT;
              default: idx_r <= '0;
            endcase
          end
        end
        S_SCAN: begin
          if (age_lt) begin
            best_r <= voice_age_r[idx_r];
            pick_r <= idx_r;
          end
          idx_r <= idx_r + 1'b1;
          if (idx_r == LAST_V) v_r <= age_lt ? idx_r : pick_r;
        end
        S_STEAL_WR: begin
          voice_busy_r[v_r] <= 1'b0;
          step_r <= 2'd0;
        end
        S_CALC: begin
          e_r    <= e_nxt;
          step_r <= step_r + 2'd1;
          if (step_r == 2'd2 && cmd_r.op == CMD_NOTE_ON) begin
            voice_busy_r[v_r]     <= 1'b1;
            voice_owner_r[v_r]    <= cmd_r.ch;
            voice_note_r[v_r]     <= cmd_r.d0;
            voice_velocity_r[v_r] <= cmd_r.d1;
            voice_age_r[v_r]      <= age_count_r + 1'b1;
            age_count_r           <= age_count_r + 1'b1;
            k_r                   <= 4'd0;
          end
        end
        S_NOTE_WR: k_r <= k_r + 4'd1;
        S_OFF_WR:  voice_busy_r[v_r] <= 1'b0;
        S_VOL_PICK: begin
          if (mask_r != '0) begin
            v_r                 <= lowest_mask;
            vel_r               <= voice_velocity_r[lowest_mask];
            mask_r[lowest_mask] <= 1'b0;
            step_r              <= 2'd0;
          end
        end
        S_ALL_WR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == LAST_V) voice_busy_r <= '0;
        end
        default: ;
      endcase
    end
  end

  a_strobe_from_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_STEAL_WR || state_r == S_NOTE_WR ||
                   state_r == S_OFF_WR || state_r == S_VOL_WR || state_r == S_ALL_WR))
    else $error("write strobe outside a write state");
  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_write) |=> (state_r == S_IDLE))
    else $error("engine kept writing after the last write of an item");
  a_note_voice_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NOTE_WR) |-> voice_busy_r[v_r])
    else $error("note writes to a voice that is not marked busy");

endmodule
`default_nettype wire

[hw/rtl/midi_fm_voice_allocator_top.sv]
// Top level of the MIDI-to-FM voice allocator: parser, command queue, voice engine.
// Depends on mfva_pkg, mfva_front, mfva_queue and mfva_back.
//
//   Channel   Ports                                         Handshake
//   input     in_midi_byte                                  start & !busy
//   result    out_reg_addr, out_reg_data, out_last_write    out_valid strobe
//   config    cfg_master_volume                             cfg_we
//
// A byte is parsed in the cycle it is taken; complete commands wait in a two-entry queue.
// The engine pops a command only when back in idle. A new note runs the level arithmetic
// and then 13 writes; with every voice busy, an age scan over all voices and a key-off
// write come first. A volume change runs a pick, the arithmetic and a carrier level write
// per affected voice. busy rises only while the queue is full. Reset is synchronous.
`default_nettype none
module midi_fm_voice_allocator_top #(
  parameter int VOICE_COUNT = 9,
  parameter int AGE_BITS    = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_midi_byte,
  output logic            out_valid,
  output logic [7:0]      out_reg_addr,
  output logic [7:0]      out_reg_data,
  output logic            out_last_write,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_master_volume
);
  import mfva_pkg::*;

  logic      accept;
  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head;
  q_status_t q_status;

  assign busy   = q_status.full;
  assign accept = start && !busy;

  mfva_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .midi_byte (in_midi_byte),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  mfva_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  mfva_back #(
    .VOICE_COUNT (VOICE_COUNT),
    .AGE_BITS    (AGE_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_master_volume (cfg_master_volume),
    .head              (head),
    .q_status          (q_status),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_reg_addr      (out_reg_addr),
    .out_reg_data      (out_reg_data),
    .out_last_write    (out_last_write)
  );

endmodule
`default_nettype wire
